// ===== rtl/core/f2d_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// f2d_pkg
// Shared types, constants and the power-of-ten table for the float to
// decimal fixed-point converter.
// ----------------------------------------------------------------------------
package f2d_pkg;

  localparam int FLOAT_W = 32;
  localparam int DP_W    = 4;
  localparam int EXP_W   = 8;
  localparam int SIG_W   = 24;              // significand with hidden one
  localparam int POW_W   = 30;              // 10^9 < 2^30
  localparam int PROD_W  = SIG_W + POW_W;   // exact product
  localparam int SUM_W   = PROD_W + 1;      // product plus half remainder
  localparam int SH_W    = 6;               // right shifts clamp at 63
  localparam int MAG_W   = PROD_W + 8;      // largest kept left shift is 8
  localparam int FIX_W   = 32;

  localparam int IN_TDATA_W  = 40;          // 36 bits of fields, byte padded
  localparam int OUT_TDATA_W = 32;

  localparam logic [EXP_W-1:0] EXP_ALL_ONES = 8'd255;
  localparam logic [EXP_W-1:0] EXP_UNITY    = 8'd150;  // bias 127 + 23 fraction bits
  localparam logic [EXP_W-1:0] LSH_SAT      = 8'd9;    // 2^23 << 9 exceeds 2^31
  localparam logic [EXP_W-1:0] RSH_MAX      = 8'd63;

  localparam logic [FIX_W-1:0] FIX_POS_MAX = 32'h7FFF_FFFF;
  localparam logic [FIX_W-1:0] FIX_NEG_MAX = 32'h8000_0000;

  typedef enum logic [1:0] {
    CLS_ZERO,     // zero or denormal
    CLS_SPECIAL,  // infinity or NaN
    CLS_NORMAL
  } cls_e;

  // decode -> multiply
  typedef struct packed {
    logic              neg;
    cls_e              cls;
    logic              right;    // exponent below unity: shift right
    logic              l_over;   // left shift large enough to always overflow
    logic [SH_W-1:0]   shamt;
    logic [SIG_W-1:0]  sig;
    logic [POW_W-1:0]  pow;
  } s1_t;

  // multiply -> scale
  typedef struct packed {
    logic              neg;
    cls_e              cls;
    logic              right;
    logic              l_over;
    logic [SH_W-1:0]   shamt;
    logic [PROD_W-1:0] prod;
  } s2_t;

  // scale -> saturate
  typedef struct packed {
    logic              neg;
    cls_e              cls;
    logic              l_over;
    logic [MAG_W-1:0]  mag;
  } s3_t;

  function automatic logic [POW_W-1:0] pow10(input logic [DP_W-1:0] idx);
    logic [POW_W-1:0] r;
    case (idx)
      4'd0:    r = 30'd1;
      4'd1:    r = 30'd10;
      4'd2:    r = 30'd100;
      4'd3:    r = 30'd1000;
      4'd4:    r = 30'd10000;
      4'd5:    r = 30'd100000;
      4'd6:    r = 30'd1000000;
      4'd7:    r = 30'd10000000;
      4'd8:    r = 30'd100000000;
      4'd9:    r = 30'd1000000000;
      default: r = 30'd1000000000;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/core/f2d_unpack.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// f2d_unpack
// Stage 1: split the single, classify it, look up the power of ten and
// work out shift direction and distance.
// ----------------------------------------------------------------------------
module f2d_unpack import f2d_pkg::*; #(
  parameter int MAX_DECIMALS = 9
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic [FLOAT_W-1:0] float_bits_i,
  input  logic [DP_W-1:0]    decimal_places_i,
  output logic               valid_o,
  input  logic               ready_i,
  output s1_t                data_o
);

  logic              valid_q;
  s1_t               data_q, data_d;
  logic [EXP_W-1:0]  exp_w, rdist, ldist;
  logic [DP_W-1:0]   dp_c;

  always_comb begin
    exp_w = float_bits_i[30:23];
    dp_c  = (decimal_places_i > DP_W'(MAX_DECIMALS)) ? DP_W'(MAX_DECIMALS)
                                                       : decimal_places_i;
    rdist = EXP_UNITY - exp_w;
    ldist = exp_w - EXP_UNITY;

    data_d.neg = float_bits_i[31];
    if (exp_w == '0) begin
      data_d.cls = CLS_ZERO;
    end else if (exp_w == EXP_ALL_ONES) begin
      data_d.cls = CLS_SPECIAL;
    end else begin
      data_d.cls = CLS_NORMAL;
    end
    data_d.right  = (exp_w < EXP_UNITY);
    data_d.l_over = !data_d.right && (ldist >= LSH_SAT);
    if (data_d.right) begin
      data_d.shamt = (rdist > RSH_MAX) ? RSH_MAX[SH_W-1:0] : rdist[SH_W-1:0];
    end else begin
      data_d.shamt = ldist[SH_W-1:0];
    end
    data_d.sig = {1'b1, float_bits_i[22:0]};
    data_d.pow = pow10(dp_c);
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== rtl/core/f2d_mul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// f2d_mul
// Stage 2: exact 24 x 30 bit product of significand and power of ten.
// ----------------------------------------------------------------------------
module f2d_mul import f2d_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  s1_t  data_i,
  output logic valid_o,
  input  logic ready_i,
  output s2_t  data_o
);

  logic valid_q;
  s2_t  data_q, data_d;

  always_comb begin
    data_d.neg    = data_i.neg;
    data_d.cls    = data_i.cls;
    data_d.right  = data_i.right;
    data_d.l_over = data_i.l_over;
    data_d.shamt  = data_i.shamt;
    data_d.prod   = PROD_W'(data_i.sig) * PROD_W'(data_i.pow);
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== rtl/core/f2d_scale.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// f2d_scale
// Stage 3: binary exponent scaling. Right shifts add half the dropped
// bits first; left shifts are plain.
// ----------------------------------------------------------------------------
module f2d_scale import f2d_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  s2_t  data_i,
  output logic valid_o,
  input  logic ready_i,
  output s3_t  data_o
);

  logic             valid_q;
  s3_t              data_q, data_d;
  logic [SUM_W-1:0] prod_x, mask, rem, sum, rmag;

  always_comb begin
    prod_x = SUM_W'(data_i.prod);
    mask   = (SUM_W'(1) << data_i.shamt) - SUM_W'(1);
    rem    = prod_x & mask;
    sum    = prod_x + (rem >> 1);
    rmag   = sum >> data_i.shamt;

    data_d.neg    = data_i.neg;
    data_d.cls    = data_i.cls;
    data_d.l_over = data_i.l_over;
    if (data_i.right) begin
      data_d.mag = MAG_W'(rmag);
    end else begin
      data_d.mag = MAG_W'(data_i.prod) << data_i.shamt[3:0];
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ===== rtl/core/f2d_sat.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// f2d_sat
// Stage 4: range check, saturation, sign and output register.
// ----------------------------------------------------------------------------
module f2d_sat import f2d_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             ready_o,
  input  s3_t              data_i,
  output logic             valid_o,
  input  logic             ready_i,
  output logic [FIX_W-1:0] fixed_value_o,
  output logic             saturated_o
);

  logic             valid_q;
  logic [FIX_W-1:0] fixed_q, fixed_d;
  logic             sat_q, sat_d;
  logic             over;
  logic [FIX_W-1:0] sat_val;

  always_comb begin
    // magnitude above 2^31-1 (positive) or above 2^31 (negative)
    over = data_i.l_over || (|data_i.mag[MAG_W-1:FIX_W]) ||
           (data_i.mag[FIX_W-1] && (!data_i.neg || (|data_i.mag[FIX_W-2:0])));
    sat_val = data_i.neg ? FIX_NEG_MAX : FIX_POS_MAX;
    case (data_i.cls)
      CLS_ZERO: begin
        fixed_d = '0;
        sat_d   = 1'b0;
      end
      CLS_SPECIAL: begin
        fixed_d = sat_val;
        sat_d   = 1'b1;
      end
      CLS_NORMAL: begin
        if (over) begin
          fixed_d = sat_val;
          sat_d   = 1'b1;
        end else begin
          fixed_d = data_i.neg ? (FIX_W'(0) - data_i.mag[FIX_W-1:0])
                               : data_i.mag[FIX_W-1:0];
          sat_d   = 1'b0;
        end
      end
      default: begin
        fixed_d = '0;
        sat_d   = 1'b0;
      end
    endcase
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      fixed_q <= fixed_d;
      sat_q   <= sat_d;
    end
  end

  assign valid_o       = valid_q;
  assign fixed_value_o = fixed_q;
  assign saturated_o   = sat_q;

endmodule

// ===== rtl/core/float_to_decimal_fixed.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// float_to_decimal_fixed
// IEEE 754 single to signed 32-bit integer scaled by 10^decimal_places,
// with half-remainder rounding on right shifts and saturation.
// ----------------------------------------------------------------------------
//
//  channel  | dir | signals                      | payload
//  ---------+-----+------------------------------+---------------------------
//  s_axis   | in  | tvalid, tready, tdata[39:0]  | float_bits, decimal_places
//  m_axis   | out | tvalid, tready, tdata, tuser | fixed_value, saturated
//
//  One transfer per cycle sustained while m_axis accepts; four register stages
//  (decode, 24x30 multiply, shift/round, saturate), in that order; the
//  saturate stage drives m_axis directly from its registers.
//  Reset clears the stage valid bits only; payload registers are not reset.
//  Each stage holds when the stage after it is full and stalled, so empty
//  stages still fill while the output waits; nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module float_to_decimal_fixed import f2d_pkg::*; #(
  parameter int MAX_DECIMALS = 9
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // [31:0] float_bits, [35:32] decimal_places, [39:36] zero
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // [31:0] fixed_value (signed)
  output logic [OUT_TDATA_W-1:0] m_axis_tdata_o,
  // [0] saturated
  output logic [0:0]             m_axis_tuser_o
);

  logic s1_valid, s1_ready;
  logic s2_valid, s2_ready;
  logic s3_valid, s3_ready;
  s1_t  s1_data;
  s2_t  s2_data;
  s3_t  s3_data;
  logic sat_w;

  // stage 1: classify, table lookup, shift distance
  f2d_unpack #(
    .MAX_DECIMALS (MAX_DECIMALS)
  ) u_unpack (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (s_axis_tvalid_i),
    .ready_o          (s_axis_tready_o),
    .float_bits_i     (s_axis_tdata_i[FLOAT_W-1:0]),
    .decimal_places_i (s_axis_tdata_i[FLOAT_W+DP_W-1:FLOAT_W]),
    .valid_o          (s1_valid),
    .ready_i          (s1_ready),
    .data_o           (s1_data)
  );

  // stage 2: exact product
  f2d_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s1_valid),
    .ready_o (s1_ready),
    .data_i  (s1_data),
    .valid_o (s2_valid),
    .ready_i (s2_ready),
    .data_o  (s2_data)
  );

  // stage 3: rounding right shift or plain left shift
  f2d_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s2_valid),
    .ready_o (s2_ready),
    .data_i  (s2_data),
    .valid_o (s3_valid),
    .ready_i (s3_ready),
    .data_o  (s3_data)
  );

  // stage 4: clamp, sign, output register
  f2d_sat u_sat (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (s3_valid),
    .ready_o       (s3_ready),
    .data_i        (s3_data),
    .valid_o       (m_axis_tvalid_o),
    .ready_i       (m_axis_tready_i),
    .fixed_value_o (m_axis_tdata_o),
    .saturated_o   (sat_w)
  );

  assign m_axis_tuser_o = sat_w;

`ifndef SYNTH
  // a saturated result is always one of the two clamp values
  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[0] |->
      (m_axis_tdata_o == FIX_POS_MAX) || (m_axis_tdata_o == FIX_NEG_MAX))
    else $error("saturated result is not a clamp value");

  // hidden one must reach the product of a normal number
  a_prod_hidden: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid && (s2_data.cls == CLS_NORMAL) |-> |s2_data.prod[PROD_W-1:SIG_W-1])
    else $error("normal product below 2^23");

  // an empty first stage always takes input
  a_in_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid |-> s_axis_tready_o)
    else $error("input stalled with empty first stage");

  // a stalled scale stage keeps its item
  a_s3_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s3_valid && !s3_ready |=> s3_valid && $stable(s3_data))
    else $error("scale stage lost or changed a stalled item");
`endif

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for float_to_decimal_fixed. Singles are sent over the
// input stream with random gaps while the output side stalls at random. Each
// accepted transfer is predicted by a local converter and the result is
// checked in order, field by field.
// ----------------------------------------------------------------------------
module tb_top;
  import f2d_pkg::*;

  localparam int CLK_PERIOD = 10;
  localparam int MAX_DP     = 9;
  localparam int DRAIN_CYC  = 8;     // pipeline is four deep
  localparam int PRINT_CAP  = 50;    // keep the log readable when things go wrong

  typedef struct packed {
    logic [FIX_W-1:0] value;
    logic             sat;
  } fixed_result_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_tvalid = 1'b0;
  logic                   s_axis_tready_o;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_axis_tvalid_o;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata_o;
  logic [0:0]             m_axis_tuser_o;

  // idle controls, switched per phase of the run
  bit          gap_en   = 1'b1;
  bit          stall_en = 1'b1;
  int unsigned ready_hold = 0;

  fixed_result_t expected_fixed_q[$];
  int unsigned   mismatch_count = 0;

  float_to_decimal_fixed #(
    .MAX_DECIMALS (MAX_DP)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_tdata),          // [31:0] float_bits, [35:32] decimal_places
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_axis_tdata_o),   // [31:0] fixed_value
    .m_axis_tuser_o  (m_axis_tuser_o)    // [0] saturated
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // Hard stop; far above the slowest legal run.
  initial begin
    #20ms;
    $display("float_to_decimal_fixed: mismatch");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Predictor: exact product of the significand and the power of ten, then a
  // binary shift. Right shifts add half the discarded bits before shifting.
  // --------------------------------------------------------------------------
  function automatic fixed_result_t predict_fixed(input logic [31:0] bits,
                                                  input logic [3:0]  dp);
    logic          neg;
    logic [7:0]    exp_f;
    logic [3:0]    dp_eff;
    logic [63:0]   scale, prod, mag, limit, rem;
    int unsigned   sh;
    bit            over;
    fixed_result_t r;
    neg    = bits[31];
    exp_f  = bits[30:23];
    limit  = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    r      = '0;
    over   = 1'b0;
    mag    = '0;
    if (exp_f == 8'd0) return r;                 // zero or denormal
    if (exp_f == EXP_ALL_ONES) begin             // infinity or NaN
      r.value = neg ? FIX_NEG_MAX : FIX_POS_MAX;
      r.sat   = 1'b1;
      return r;
    end
    dp_eff = (dp > MAX_DP) ? 4'(MAX_DP) : dp;
    scale  = 64'd1;
    repeat (dp_eff) scale = scale * 64'd10;
    prod = {40'd0, 1'b1, bits[22:0]} * scale;
    if (exp_f < EXP_UNITY) begin
      sh = 32'(EXP_UNITY - exp_f);
      if (sh >= 64) begin
        mag = '0;
      end else begin
        rem = prod & ((64'd1 << sh) - 64'd1);
        mag = (prod + (rem >> 1)) >> sh;
      end
      over = (mag > limit);
    end else begin
      sh = 32'(exp_f - EXP_UNITY);
      if (sh >= 32 || prod > (limit >> sh)) over = 1'b1;
      else mag = prod << sh;
    end
    if (over) begin
      r.value = neg ? FIX_NEG_MAX : FIX_POS_MAX;
      r.sat   = 1'b1;
    end else begin
      r.value = neg ? (32'd0 - mag[31:0]) : mag[31:0];
    end
    return r;
  endfunction

  // mostly short idles, now and then a long one
  function automatic int unsigned idle_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  task automatic report_mismatch(input string msg);
    if (mismatch_count < PRINT_CAP) $display("ERROR %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // One input transfer. Called and returns at a rising edge; valid stays high
  // into the next call unless that call opens a gap.
  task automatic send_conversion(input logic [31:0] bits, input logic [3:0] dp);
    int unsigned gap;
    gap = (gap_en && $urandom_range(0, 2) == 0) ? idle_len() : 0;
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {4'b0000, dp, bits};
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    expected_fixed_q.push_back(predict_fixed(bits, dp));
  endtask

  // Output back-pressure: runs of ready and runs of stall.
  always @(posedge clk_i) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (!stall_en) begin
      m_tready <= 1'b1;
    end else if ($urandom_range(0, 3) == 0) begin
      m_tready   <= 1'b0;
      ready_hold <= idle_len();
    end else begin
      m_tready   <= 1'b1;
      ready_hold <= $urandom_range(0, 4);
    end
  end

  // Result checker: every output transfer against the oldest prediction.
  always @(posedge clk_i) begin
    fixed_result_t want;
    if (rst_ni && m_axis_tvalid_o && m_tready) begin
      if (expected_fixed_q.size() == 0) begin
        report_mismatch($sformatf("unexpected result value=%h sat=%0d",
                                  m_axis_tdata_o, m_axis_tuser_o[0]));
      end else begin
        want = expected_fixed_q.pop_front();
        if (m_axis_tdata_o !== want.value)
          report_mismatch($sformatf("fixed_value got %h want %h",
                                    m_axis_tdata_o, want.value));
        if (m_axis_tuser_o[0] !== want.sat)
          report_mismatch($sformatf("saturated got %b want %b",
                                    m_axis_tuser_o[0], want.sat));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Directed tests
  // --------------------------------------------------------------------------
  task automatic test_zero_and_denormal();
    send_conversion(32'h0000_0000, 4'd0);   // +0
    send_conversion(32'h8000_0000, 4'd9);   // -0
    send_conversion(32'h007F_FFFF, 4'd9);   // largest denormal
    send_conversion(32'h8000_0001, 4'd3);   // smallest negative denormal
  endtask

  task automatic test_inf_and_nan();
    send_conversion(32'h7F80_0000, 4'd0);   // +inf
    send_conversion(32'hFF80_0000, 4'd5);   // -inf
    send_conversion(32'h7FC0_0000, 4'd9);   // quiet NaN
    send_conversion(32'hFFFF_FFFF, 4'd15);  // negative NaN, all ones
  endtask

  task automatic test_rounding_and_small();
    send_conversion(32'h3F80_0000, 4'd0);   // 1.0
    send_conversion(32'hBFC0_0000, 4'd1);   // -1.5 -> -15
    send_conversion(32'h3F00_0000, 4'd0);   // 0.5
    send_conversion(32'hBF00_0000, 4'd0);   // -0.5, rounds to zero magnitude
    send_conversion(32'h0080_0000, 4'd9);   // smallest normal: shift far past 64
    send_conversion(32'h2B00_0000, 4'd9);   // right shift of exactly 64
    send_conversion(32'h2B80_0000, 4'd9);   // right shift of 63
  endtask

  task automatic test_overflow_edges();
    send_conversion(32'h4F00_0000, 4'd0);   // +2^31: clamps
    send_conversion(32'hCF00_0000, 4'd0);   // -2^31: fits exactly
    send_conversion(32'h4EFF_FFFF, 4'd0);   // largest single below 2^31
    send_conversion(32'h7F7F_FFFF, 4'd9);   // largest finite, huge left shift
    send_conversion(32'h4000_0000, 4'd9);   // 2.0e9 fits
    send_conversion(32'h4040_0000, 4'd9);   // 3.0e9 clamps
    send_conversion(32'hC040_0000, 4'd9);   // -3.0e9 clamps
  endtask

  task automatic test_places_out_of_range();
    send_conversion(32'h3F80_0000, 4'd10);
    send_conversion(32'hBF80_0000, 4'd15);
    send_conversion(32'h3DCC_CCCD, 4'd12);  // 0.1
  endtask

  // --------------------------------------------------------------------------
  // Random conversions; exponents weighted toward the range where scaling,
  // rounding and clamping all matter.
  // --------------------------------------------------------------------------
  task automatic test_random_conversions(input int unsigned count);
    logic [31:0] bits;
    logic [7:0]  exp_f;
    logic [22:0] frac;
    logic [3:0]  dp;
    for (int unsigned i = 0; i < count; i++) begin
      frac = 23'($urandom());
      case ($urandom_range(0, 7))
        0: frac = '0;
        1: frac = '1;
        default: ;
      endcase
      case ($urandom_range(0, 9))
        0:       exp_f = 8'($urandom_range(0, 255));
        1:       exp_f = ($urandom_range(0, 1) != 0) ? EXP_ALL_ONES : 8'd0;
        2:       exp_f = 8'($urandom_range(1, 100));
        default: exp_f = 8'($urandom_range(110, 160));
      endcase
      bits = {1'($urandom_range(0, 1)), exp_f, frac};
      if ($urandom_range(0, 15) == 0) bits = $urandom();
      dp = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(10, 15))
                                       : 4'($urandom_range(0, MAX_DP));
      send_conversion(bits, dp);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_zero_and_denormal();
    test_inf_and_nan();
    test_rounding_and_small();
    test_overflow_edges();
    test_places_out_of_range();

    // gaps and stalls together, then each alone, then full rate, then both again
    test_random_conversions(400);
    stall_en = 1'b0;
    test_random_conversions(350);
    gap_en   = 1'b0;
    stall_en = 1'b1;
    test_random_conversions(350);
    stall_en = 1'b0;
    test_random_conversions(200);
    gap_en   = 1'b1;
    stall_en = 1'b1;
    test_random_conversions(200);

    s_tvalid <= 1'b0;
    while (expected_fixed_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("float_to_decimal_fixed: match");
    end else begin
      $display("float_to_decimal_fixed: mismatch");
    end
    $finish;
  end

endmodule
